[hw/rtl/efms_pkg.sv]
// Package for the earliest-free-machine scheduler: field widths, request and
// result payload types, and the result type of the shared compare/add unit.
// No dependencies.
package efms_pkg;

    localparam int MAX_MACHINES_DEF = 64;
    localparam int TIME_W           = 31;
    localparam int FIN_W            = 32;
    localparam int MC_W             = 7;
    localparam logic [MC_W-1:0] MC_RESET = 7'd1;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] duration;
        logic              last_task;
    } efms_task_t;

    typedef struct packed {
        logic [FIN_W-1:0] finish_time;
        logic [FIN_W-1:0] makespan;
        logic             job_done;
    } efms_result_t;

    typedef struct packed {
        logic             gt;
        logic [FIN_W-1:0] sum_sat;
    } efms_alu_res_t;

endpackage

[hw/rtl/efms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module efms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/efms_alu.sv]
// Shared arithmetic unit: unsigned greater-than compare and 32-bit saturating add.
// Depends on efms_pkg.
module efms_alu
    import efms_pkg::*;
(
    input  logic [FIN_W-1:0] a,
    input  logic [FIN_W-1:0] b,
    output efms_alu_res_t    res
);

    logic [FIN_W:0] sum_full;

    assign sum_full = {1'b0, a} + {1'b0, b};

    always_comb begin
        res.gt      = (a > b);
        // clamp to all ones on carry out
        res.sum_sat = sum_full[FIN_W] ? {FIN_W{1'b1}} : sum_full[FIN_W-1:0];
    end

endmodule

[hw/rtl/earliest_free_machine_scheduler.sv]
// A task that still finds an unused machine appends its finish time to the heap and lifts it
// toward the root; otherwise it replaces the root (earliest free machine) and sifts it down.
// A new request is taken only after the last result has gone to the output register, which
// waits while an earlier result is held; every level costs a read of the heap RAM plus a pass
// through the one compare/add unit.
// Reset (aresetn low, synchronous): empty heap, makespan zero, machine count 1.
module earliest_free_machine_scheduler
    import efms_pkg::*;
#(
    parameter int MAX_MACHINES = MAX_MACHINES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    // task requests
    input  logic            s_valid,
    output logic            s_ready,
    input  efms_task_t      s_task,
    // results
    output logic            m_valid,
    input  logic            m_ready,
    output efms_result_t    m_result,
    // machine count register
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [MC_W-1:0] cfg_data
);

    // heap index width, fill count width (must hold MAX_MACHINES itself),
    // and child index width (2i+2 needs two more bits than i)
    localparam int AW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int FW = $clog2(MAX_MACHINES + 1);
    localparam int CW = AW + 2;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;  // wait for a request
    localparam logic [3:0] S_ROOT = 4'd1;  // read the root (earliest free machine)
    localparam logic [3:0] S_MAX  = 4'd2;  // base = max(root, start)
    localparam logic [3:0] S_ADD  = 4'd3;  // finish = base + duration, saturated
    localparam logic [3:0] S_UP   = 4'd4;  // sift-up: read parent of hole
    localparam logic [3:0] S_UPC  = 4'd5;  // sift-up: compare parent, move hole
    localparam logic [3:0] S_DN   = 4'd6;  // sift-down: read left child
    localparam logic [3:0] S_DNL  = 4'd7;  // sift-down: compare left, read right
    localparam logic [3:0] S_DNR  = 4'd8;  // sift-down: compare right, move hole
    localparam logic [3:0] S_DONE = 4'd9;  // update makespan, hand off result

    logic [3:0]       state_reg, state_next;
    efms_task_t       task_reg, task_next;
    logic [FIN_W-1:0] base_reg, base_next;
    logic [FIN_W-1:0] val_reg, val_next;     // finish time, also the value being sifted
    logic [FIN_W-1:0] cand_reg, cand_next;   // smaller of hole value and left child
    logic             cand_l_reg, cand_l_next;
    logic [AW-1:0]    idx_reg, idx_next;     // current hole position
    logic [FW-1:0]    fill_reg, fill_next;
    logic [FIN_W-1:0] latest_reg, latest_next;
    logic [MC_W-1:0]  mc_reg;
    logic             push_reg, push_next;
    logic             m_valid_reg, m_valid_next;
    efms_result_t     m_result_reg, m_result_next;

    logic [FW-1:0]    mach_eff;
    logic [CW-1:0]    lchild, rchild;
    logic [AW-1:0]    parent;
    logic             l_in_heap, r_in_heap;

    logic [FIN_W-1:0] alu_a, alu_b;
    efms_alu_res_t    alu_res;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [FIN_W-1:0] ram_wdata, ram_rdata;

    efms_ram #(
        .WIDTH (FIN_W),
        .DEPTH (MAX_MACHINES)
    ) u_heap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    efms_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_result  = m_result_reg;

    // clamp the machine count into 1..MAX_MACHINES
    always_comb begin
        if (mc_reg == '0) begin
            mach_eff = FW'(1);
        end else if (32'(mc_reg) > 32'(MAX_MACHINES)) begin
            mach_eff = FW'(MAX_MACHINES);
        end else begin
            mach_eff = FW'(mc_reg);
        end
    end

    // heap navigation around the hole
    assign lchild    = CW'({idx_reg, 1'b1});
    assign rchild    = lchild + CW'(1);
    assign parent    = AW'((idx_reg - AW'(1)) >> 1);
    assign l_in_heap = (32'(lchild) < 32'(fill_reg));
    assign r_in_heap = (32'(rchild) < 32'(fill_reg));

    // operand select for the shared unit
    always_comb begin
        unique case (state_reg)
            S_MAX: begin
                alu_a = ram_rdata;
                alu_b = {1'b0, task_reg.start_time};
            end
            S_ADD: begin
                alu_a = base_reg;
                alu_b = {1'b0, task_reg.duration};
            end
            S_UPC: begin
                alu_a = ram_rdata;
                alu_b = val_reg;
            end
            S_DNL: begin
                alu_a = val_reg;
                alu_b = ram_rdata;
            end
            S_DNR: begin
                alu_a = cand_reg;
                alu_b = ram_rdata;
            end
            default: begin
                alu_a = val_reg;
                alu_b = latest_reg;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        task_next     = task_reg;
        base_next     = base_reg;
        val_next      = val_reg;
        cand_next     = cand_reg;
        cand_l_next   = cand_l_reg;
        idx_next      = idx_reg;
        fill_next     = fill_reg;
        latest_next   = latest_reg;
        push_next     = push_reg;
        m_valid_next  = m_valid_reg;
        m_result_next = m_result_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = val_reg;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        // drop the result once the sink takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    task_next = s_task;
                    base_next = {1'b0, s_task.start_time};
                    // a free machine is still unused: grow the heap
                    push_next = (fill_reg < mach_eff);
                    state_next = (fill_reg < mach_eff) ? S_ADD : S_ROOT;
                end
            end
            S_ROOT: begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                state_next = S_MAX;
            end
            S_MAX: begin
                base_next  = alu_res.gt ? ram_rdata : {1'b0, task_reg.start_time};
                state_next = S_ADD;
            end
            S_ADD: begin
                val_next = alu_res.sum_sat;
                if (push_reg) begin
                    idx_next   = AW'(fill_reg);
                    fill_next  = fill_reg + FW'(1);
                    state_next = S_UP;
                end else begin
                    idx_next   = '0;
                    state_next = S_DN;
                end
            end
            S_UP: begin
                if (idx_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = parent;
                    state_next = S_UPC;
                end
            end
            S_UPC: begin
                if (alu_res.gt) begin
                    // parent is later: move it down, advance hole upward
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    idx_next   = parent;
                    state_next = S_UP;
                end else begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN: begin
                if (l_in_heap) begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(lchild);
                    state_next = S_DNL;
                end else begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DNL: begin
                cand_next   = alu_res.gt ? ram_rdata : val_reg;
                cand_l_next = alu_res.gt;
                if (r_in_heap) begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(rchild);
                    state_next = S_DNR;
                end else if (alu_res.gt) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    idx_next   = AW'(lchild);
                    state_next = S_DN;
                end else begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DNR: begin
                if (alu_res.gt) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    idx_next   = AW'(rchild);
                    state_next = S_DN;
                end else if (cand_l_reg) begin
                    ram_we     = 1'b1;
                    ram_wdata  = cand_reg;
                    idx_next   = AW'(lchild);
                    state_next = S_DN;
                end else begin
                    ram_we     = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_result_next.finish_time = val_reg;
                    m_result_next.makespan    = alu_res.gt ? val_reg : latest_reg;
                    m_result_next.job_done    = task_reg.last_task;
                    if (task_reg.last_task) begin
                        // job over: empty the heap and restart the makespan
                        fill_next   = '0;
                        latest_next = '0;
                    end else begin
                        latest_next = alu_res.gt ? val_reg : latest_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            latest_reg  <= '0;
            mc_reg      <= MC_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            latest_reg  <= latest_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                mc_reg <= cfg_data;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        task_reg     <= task_next;
        base_reg     <= base_next;
        val_reg      <= val_next;
        cand_reg     <= cand_next;
        cand_l_reg   <= cand_l_next;
        idx_reg      <= idx_next;
        push_reg     <= push_next;
        m_result_reg <= m_result_next;
    end

endmodule

[hw/rtl/efms_checker.sv]
// Port-level checker for the scheduler, bound to the top level.
// Depends on efms_pkg and earliest_free_machine_scheduler.
module efms_checker
    import efms_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_valid,
    input logic         s_ready,
    input efms_task_t   s_task,
    input logic         m_valid,
    input logic         m_ready,
    input efms_result_t m_result
);

    // one request at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one in flight");

    // makespan covers the task it is reported with
    a_makespan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result.makespan >= m_result.finish_time))
        else $error("makespan below finish time");

    // hold a stalled result, unchanged, until the sink takes it
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result)))
        else $error("stalled result changed or dropped");

endmodule

bind earliest_free_machine_scheduler efms_checker u_efms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_task   (s_task),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);

[test/earliest_free_machine_scheduler_checker.sv]
`timescale 1ns / 1ps
// Result checker for the earliest-free-machine scheduler: follows the request,
// result and machine-count channels, keeps its own free-time heap and compares
// every result against it. Depends on efms_pkg.
module earliest_free_machine_scheduler_checker
    import efms_pkg::*;
#(
    parameter int MACHINE_LIMIT = MAX_MACHINES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  efms_task_t      s_task,
    input  logic            m_valid,
    input  logic            m_ready,
    input  efms_result_t    m_result,
    input  logic            cfg_valid,
    input  logic            cfg_ready,
    input  logic [MC_W-1:0] cfg_data,
    output int unsigned     fail_count,
    output int unsigned     pending,
    output int unsigned     results_checked
);

    logic [FIN_W-1:0] free_times [MACHINE_LIMIT];
    int unsigned      busy_machines;
    logic [FIN_W-1:0] job_makespan;
    logic [MC_W-1:0]  machine_setting;
    efms_result_t     expected_results [$];

    function automatic logic [FIN_W-1:0] add_saturated(logic [FIN_W-1:0] a,
                                                        logic [FIN_W-1:0] b);
        logic [FIN_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[FIN_W] ? {FIN_W{1'b1}} : total[FIN_W-1:0];
    endfunction

    function automatic void swap_free_times(int unsigned a, int unsigned b);
        logic [FIN_W-1:0] held;
        held = free_times[a];
        free_times[a] = free_times[b];
        free_times[b] = held;
    endfunction

    // Append and sift up toward the root.
    function automatic void insert_free_time(logic [FIN_W-1:0] value);
        int unsigned idx;
        int unsigned parent;
        idx = busy_machines;
        if (idx >= MACHINE_LIMIT)
            return;
        free_times[idx] = value;
        busy_machines = idx + 1;
        while (idx > 0) begin
            parent = (idx - 1) / 2;
            if (free_times[parent] <= free_times[idx])
                break;
            swap_free_times(parent, idx);
            idx = parent;
        end
    endfunction

    // Overwrite the root and sift down over the current heap size.
    function automatic void replace_earliest(logic [FIN_W-1:0] value);
        int unsigned size;
        int unsigned idx;
        int unsigned left;
        int unsigned right;
        int unsigned best;
        size = (busy_machines > MACHINE_LIMIT) ? MACHINE_LIMIT : busy_machines;
        idx = 0;
        free_times[0] = value;
        while (1) begin
            left = 2 * idx + 1;
            right = left + 1;
            best = idx;
            if (left < size && free_times[best] > free_times[left])
                best = left;
            if (right < size && free_times[best] > free_times[right])
                best = right;
            if (best == idx)
                break;
            swap_free_times(best, idx);
            idx = best;
        end
    endfunction

    function automatic efms_result_t schedule_task(efms_task_t req);
        int unsigned      machines;
        logic [FIN_W-1:0] start_t;
        logic [FIN_W-1:0] freed;
        logic [FIN_W-1:0] finish;
        efms_result_t     res;
        machines = machine_setting;
        if (machines == 0)
            machines = 1;
        if (machines > MACHINE_LIMIT)
            machines = MACHINE_LIMIT;
        start_t = {1'b0, req.start_time};
        if (busy_machines < machines) begin
            finish = add_saturated(start_t, {1'b0, req.duration});
            insert_free_time(finish);
        end else begin
            freed = free_times[0];
            finish = add_saturated((freed > start_t) ? freed : start_t,
                                   {1'b0, req.duration});
            replace_earliest(finish);
        end
        if (finish > job_makespan)
            job_makespan = finish;
        res.finish_time = finish;
        res.makespan = job_makespan;
        res.job_done = req.last_task;
        if (req.last_task) begin
            busy_machines = 0;
            job_makespan = '0;
        end
        return res;
    endfunction

    always @(posedge aclk) begin : track_schedule
        efms_result_t want;
        if (!aresetn) begin
            busy_machines = 0;
            job_makespan = '0;
            machine_setting = MC_RESET;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
            results_checked = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: finish_time %h makespan %h",
                           m_result.finish_time, m_result.makespan);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (m_result.finish_time !== want.finish_time) begin
                        $error("finish_time mismatch: expected %h, actual %h",
                               want.finish_time, m_result.finish_time);
                        fail_count++;
                    end
                    if (m_result.makespan !== want.makespan) begin
                        $error("makespan mismatch: expected %h, actual %h",
                               want.makespan, m_result.makespan);
                        fail_count++;
                    end
                    if (m_result.job_done !== want.job_done) begin
                        $error("job_done mismatch: expected %b, actual %b",
                               want.job_done, m_result.job_done);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                machine_setting = cfg_data;
            if (s_valid && s_ready)
                expected_results.push_back(schedule_task(s_task));
            pending = expected_results.size();
        end
    end

endmodule

[test/earliest_free_machine_scheduler_test.sv]
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, request and machine-count
// stimulus, result back-pressure and the verdict. Depends on efms_pkg, the
// scheduler RTL and earliest_free_machine_scheduler_checker.
module earliest_free_machine_scheduler_test;
    import efms_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    // Exceeds the longest request-to-result path at 64 machines, with margin.
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_STALL    = 400;
    localparam int PHASE_TASKS   = 360;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    efms_task_t      s_task;
    logic            m_valid;
    logic            m_ready;
    efms_result_t    m_result;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [MC_W-1:0] cfg_data;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned results_checked;

    // Knobs for the current idling phase, in percent of cycles.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    // Toggle to ask the result side for one long hold-off.
    logic        long_stall_toggle;
    logic        long_stall_seen;
    int unsigned stall_left;

    int unsigned tasks_sent;
    int unsigned jobs_closed;
    int unsigned cfg_writes;
    int unsigned cycle_count;

    earliest_free_machine_scheduler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_task    (s_task),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    earliest_free_machine_scheduler_checker checker_inst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_task          (s_task),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result        (m_result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Guard against a hung block: end the run as failed past the cycle limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: honor a pending long hold-off first, else stall at random
    // at the phase's rate. Changes land on the falling edge.
    always @(negedge aclk) begin
        if (long_stall_toggle != long_stall_seen) begin
            long_stall_seen <= long_stall_toggle;
            stall_left <= LONG_STALL;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Mostly small times so that heap order matters; sometimes the full range
    // or values near the top to exercise saturation and every bit.
    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(7))
            0: return TIME_W'($urandom());
            1: return {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 15));
            default: return TIME_W'($urandom_range(0, 3000));
        endcase
    endfunction

    function automatic logic [MC_W-1:0] pick_machine_count();
        case ($urandom_range(9))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd2;
            3: return 7'd3;
            4: return 7'd64;
            5: return 7'd127;
            6: return MC_W'($urandom_range(65, 127));
            7: return MC_W'($urandom_range(0, 127));
            default: return MC_W'($urandom_range(1, 64));
        endcase
    endfunction

    // Enter and leave on a falling edge. Valid is left high on return so the
    // next request can follow back to back; whoever acts next sets it.
    task automatic send_request(input logic [TIME_W-1:0] start_t,
                                input logic [TIME_W-1:0] dur,
                                input logic              last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_task <= '{start_time: start_t, duration: dur, last_task: last};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
        tasks_sent++;
        if (last)
            jobs_closed++;
    endtask

    // Hold requests until every expected result is back, then let the block
    // settle in case it is still finishing a sift.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_machine_count(input logic [MC_W-1:0] count);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= count;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // One random round: new machine count, then a few jobs. Now and then a
    // job is left open so the next count applies mid-job.
    task automatic run_random_round();
        logic [MC_W-1:0] setting;
        int unsigned     machines;
        int unsigned     jobs;
        int unsigned     len;
        bit              keep_open;
        setting = pick_machine_count();
        machines = (setting == 0) ? 1 : (setting > MAX_MACHINES_DEF) ? MAX_MACHINES_DEF
                                                                      : setting;
        write_machine_count(setting);
        jobs = $urandom_range(1, 3);
        repeat (jobs) begin
            len = $urandom_range(1, 2 * machines + 4);
            keep_open = ($urandom_range(5) == 0);
            for (int i = 0; i < len; i++)
                send_request(pick_time(), pick_time(), (i == len - 1) && !keep_open);
        end
    endtask

    initial begin : stimulus
        int unsigned phase_start;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_task = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_stall_toggle = 1'b0;
        long_stall_seen = 1'b0;
        stall_left = 0;
        tasks_sent = 0;
        jobs_closed = 0;
        cfg_writes = 0;
        cycle_count = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset count of one machine: extreme fields, then chain to saturate.
        send_request('0, '0, 1'b0);
        send_request({TIME_W{1'b1}}, {TIME_W{1'b1}}, 1'b0);
        send_request('0, 31'd2, 1'b0);
        send_request('0, '0, 1'b1);

        // Zero machines acts as one.
        write_machine_count(7'd0);
        send_request(31'd5, 31'd10, 1'b0);
        send_request('0, 31'd3, 1'b1);

        // Beyond the limit clamps to the full machine set.
        write_machine_count(7'd127);
        send_request(31'd100, 31'd1, 1'b0);
        send_request(31'd50, 31'd2, 1'b0);
        send_request(31'd200, 31'd3, 1'b0);
        send_request(31'd10, 31'd4, 1'b0);
        send_request(31'd0, 31'd7, 1'b1);

        // Fill four machines, then lower the count mid-job: heap stays at four.
        write_machine_count(7'd4);
        send_request(31'd40, 31'd5, 1'b0);
        send_request(31'd10, 31'd30, 1'b0);
        send_request(31'd0, 31'd8, 1'b0);
        send_request(31'd25, 31'd1, 1'b0);
        send_request(31'd3, 31'd6, 1'b0);
        send_request(31'd90, 31'd2, 1'b0);
        write_machine_count(7'd2);
        send_request(31'd0, 31'd11, 1'b0);
        send_request(31'd70, 31'd4, 1'b0);
        send_request(31'd1, 31'd1, 1'b1);

        write_machine_count(7'd64);
        send_request(31'd7, 31'd7, 1'b0);
        send_request(31'd2, 31'd9, 1'b1);

        // Back-pressure: hold the result side off while requests keep coming,
        // so the block fills and stops taking requests; then wait for all.
        drain_results();
        long_stall_toggle <= ~long_stall_toggle;
        for (int i = 0; i < 24; i++)
            send_request(pick_time(), pick_time(), (i % 8) == 7);
        drain_results();

        // Random phases: no idling, idle requests, stalled results, both.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            phase_start = tasks_sent;
            while (tasks_sent - phase_start < PHASE_TASKS)
                run_random_round();
        end

        drain_results();
        $display("Covered %0d requests in %0d closed jobs across %0d machine-count writes;",
                 tasks_sent, jobs_closed, cfg_writes);
        $display("%0d results compared, %0d mismatches.", results_checked, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
